// ===== rtl/core/fss_pkg.sv =====
package fss_pkg;

   // Working width of the alignment sums
   localparam int SCORE_W = 16;
   // Width of the delivered score
   localparam int RSP_W = 13;

   localparam int DEF_MAX_PATTERN = 32;
   localparam int DEF_MAX_TEXT = 256;

   localparam int SCORE_BASE = 100;
   localparam int BONUS_ADJACENT = 15;
   localparam int BONUS_CAMEL = 30;
   localparam int BONUS_SEPARATOR = 30;
   localparam int BONUS_FIRST = 15;
   localparam int PENALTY_LEADING = -5;
   localparam int PENALTY_LEADING_MAX = -15;

   typedef logic signed [SCORE_W-1:0] score_type;

   // Broadcast to every cell for one beat
   typedef struct packed {
      logic       step;
      logic       clear;
      logic [7:0] ch_fold;
      score_type  ctx;
      score_type  first_bonus;
   } cell_ctrl_type;

   // What one cell hands to its right-hand neighbor
   typedef struct packed {
      logic      at_v;
      score_type at;
      logic      bef_v;
      score_type bef;
   } cell_link_type;

   // Result stage contents ahead of the final sum
   typedef struct packed {
      logic      empty;
      logic      fin_v;
      score_type fin;
      score_type unmatched;
      logic      overflow;
   } result_pre_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_upper(c) || is_lower(c) || ((c >= 8'h30) && (c <= 8'h39));
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return is_upper(c) ? (c + 8'd32) : c;
   endfunction

   function automatic score_type context_bonus(input logic [7:0] prev, input logic [7:0] cur);
      score_type s;
      s = '0;
      if (is_upper(cur) && is_lower(prev)) begin
         s = s + SCORE_W'(BONUS_CAMEL);
      end
      if (is_alnum(cur) && !is_alnum(prev)) begin
         s = s + SCORE_W'(BONUS_SEPARATOR);
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/fss_cell.sv =====
module fss_cell #(
   parameter bit FIRST = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fss_pkg::cell_ctrl_type ctrl,
   input  logic                  load,
   input  logic [7:0]            load_char,
   input  fss_pkg::cell_link_type prev,
   output fss_pkg::cell_link_type link,
   output logic                  fin_v,
   output fss_pkg::score_type    fin
);
   import fss_pkg::*;

   logic [7:0] pchar_ff, pchar_in;
   logic       at_v_ff, at_v_in;
   score_type  at_ff, at_in;
   logic       bef_v_ff, bef_v_in;
   score_type  bef_ff, bef_in;

   logic       hit;
   logic       choose_adj;
   score_type  cand_adj;
   logic       nv;
   score_type  na;
   logic       nbef_v;
   score_type  nbef;
   logic       view_at_v, view_bef_v;
   score_type  view_at, view_bef;

   always_comb begin
      hit = (pchar_ff == ctrl.ch_fold);
      cand_adj = prev.at + SCORE_W'(BONUS_ADJACENT);
      choose_adj = prev.at_v && !(prev.bef_v && (prev.bef > cand_adj));
      if (FIRST) begin
         nv = hit;
         na = ctrl.first_bonus;
      end else begin
         nv = hit && (prev.at_v || prev.bef_v);
         na = (choose_adj ? cand_adj : prev.bef) + ctrl.ctx;
      end
      nbef_v = bef_v_ff || at_v_ff;
      nbef = (at_v_ff && (!bef_v_ff || (at_ff > bef_ff))) ? at_ff : bef_ff;
   end

   // Final answer of this cell as seen after the current beat
   always_comb begin
      view_at_v  = ctrl.step ? nv : at_v_ff;
      view_at    = ctrl.step ? na : at_ff;
      view_bef_v = ctrl.step ? nbef_v : bef_v_ff;
      view_bef   = ctrl.step ? nbef : bef_ff;
      fin_v = view_at_v || view_bef_v;
      fin = (view_bef_v && (!view_at_v || (view_bef > view_at))) ? view_bef : view_at;
   end

   always_comb begin
      pchar_in = load ? fold(load_char) : pchar_ff;
      at_v_in  = at_v_ff;
      at_in    = at_ff;
      bef_v_in = bef_v_ff;
      bef_in   = bef_ff;
      if (ctrl.clear) begin
         at_v_in  = 1'b0;
         bef_v_in = 1'b0;
      end else if (ctrl.step) begin
         at_v_in  = nv;
         at_in    = na;
         bef_v_in = nbef_v;
         bef_in   = nbef;
      end
   end

   always_ff @(posedge clock) begin
      pchar_ff <= pchar_in;
      at_ff    <= at_in;
      bef_ff   <= bef_in;
      if (reset) begin
         at_v_ff  <= 1'b0;
         bef_v_ff <= 1'b0;
      end else begin
         at_v_ff  <= at_v_in;
         bef_v_ff <= bef_v_in;
      end
   end

   assign link.at_v  = at_v_ff;
   assign link.at    = at_ff;
   assign link.bef_v = bef_v_ff;
   assign link.bef   = bef_ff;

endmodule

// ===== rtl/core/fss_score.sv =====
module fss_score (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pre_valid,
   input  fss_pkg::result_pre_type       pre,
   output logic                          out_can,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [fss_pkg::RSP_W-1:0] rsp_match_score,
   output logic                          rsp_matched,
   output logic                          rsp_too_long
);
   import fss_pkg::*;

   localparam int SUM_W = SCORE_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (RSP_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(2 ** (RSP_W - 1));

   logic                    valid_ff, valid_in;
   logic signed [RSP_W-1:0] score_ff, score_in;
   logic                    matched_ff, matched_in;
   logic                    too_long_ff, too_long_in;

   logic signed [SUM_W-1:0] sum;
   logic                    take;

   assign out_can = !valid_ff || !rsp_stall;
   assign take = pre_valid && out_can;

   always_comb begin
      sum = SUM_W'(SCORE_BASE) - SUM_W'(pre.unmatched) + SUM_W'(pre.fin);
      valid_in    = valid_ff;
      score_in    = score_ff;
      matched_in  = matched_ff;
      too_long_in = too_long_ff;
      if (take) begin
         valid_in    = 1'b1;
         too_long_in = pre.overflow;
         if (pre.empty) begin
            score_in   = RSP_W'(SCORE_BASE);
            matched_in = 1'b1;
         end else if (pre.fin_v) begin
            matched_in = 1'b1;
            if (sum > SAT_HI) begin
               score_in = SAT_HI[RSP_W-1:0];
            end else if (sum < SAT_LO) begin
               score_in = SAT_LO[RSP_W-1:0];
            end else begin
               score_in = sum[RSP_W-1:0];
            end
         end else begin
            score_in   = '0;
            matched_in = 1'b0;
         end
      end else if (out_can) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      score_ff    <= score_in;
      matched_ff  <= matched_in;
      too_long_ff <= too_long_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_match_score = score_ff;
   assign rsp_matched     = matched_ff;
   assign rsp_too_long    = too_long_ff;

endmodule

// ===== rtl/core/fuzzy_subsequence_scorer_core.sv =====
// Fuzzy subsequence scorer. Load a pattern one byte per beat (req_operation 0,
// req_last on the final byte), then stream a text (req_operation 1); the beat
// with req_last set on the text yields one result beat with the score, the
// match flag and the overflow flag. Beats go one per cycle unless stalled:
// a row of MAX_PATTERN cells, one per pattern byte, updates all alignment sums
// in the cycle a text byte arrives, each cell fed by its left neighbor. The
// result leaves through a result stage and an output register; the input
// stalls only on a last text beat while both of those are held by a
// stalled output. Pattern bytes beyond MAX_PATTERN are dropped and text
// beyond MAX_TEXT sets the overflow flag. No clearing pass follows reset.
module fuzzy_subsequence_scorer_core #(
   parameter int MAX_PATTERN = fss_pkg::DEF_MAX_PATTERN,
   parameter int MAX_TEXT    = fss_pkg::DEF_MAX_TEXT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [7:0]                    req_character,
   input  logic                          req_has_character,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [fss_pkg::RSP_W-1:0] rsp_match_score,
   output logic                          rsp_matched,
   output logic                          rsp_too_long
);
   import fss_pkg::*;

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int TC_W  = $clog2(MAX_TEXT + 1);

   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic             pdone_ff, pdone_in;
   logic [TC_W-1:0]  tcount_ff, tcount_in;
   logic [7:0]       prev_char_ff, prev_char_in;
   logic             overflow_ff, overflow_in;
   logic             pre_valid_ff, pre_valid_in;
   result_pre_type   pre_ff, pre_in;

   logic             accept, pat_beat, text_step, text_end;
   logic             out_can;
   logic [CNT_W-1:0] eff_count;
   logic [TC_W-1:0]  tcount_step;
   logic             overflow_step;
   score_type        ctx, pen;
   cell_ctrl_type    ctrl;
   logic [MAX_PATTERN-1:0] load_vec;
   cell_link_type    links [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] fin_v;
   score_type        fin [MAX_PATTERN];
   logic             tail_v;
   score_type        tail;

   // A last text beat needs room in the result stage
   assign req_stall = pre_valid_ff && !out_can && req_valid && req_operation && req_last;
   assign accept    = req_valid && !req_stall;
   assign pat_beat  = accept && !req_operation;
   assign text_step = accept && req_operation && req_has_character;
   assign text_end  = accept && req_operation && req_last;

   assign eff_count = pdone_ff ? '0 : pcount_ff;

   always_comb begin
      ctx = context_bonus(prev_char_ff, req_character);
      if (tcount_ff >= TC_W'(3)) begin
         pen = SCORE_W'(PENALTY_LEADING_MAX);
      end else begin
         pen = SCORE_W'(PENALTY_LEADING) * SCORE_W'(tcount_ff);
      end
      ctrl.step        = text_step;
      ctrl.clear       = pat_beat || text_end;
      ctrl.ch_fold     = fold(req_character);
      ctrl.ctx         = ctx;
      ctrl.first_bonus = (tcount_ff == '0) ? SCORE_W'(BONUS_FIRST) : (ctx + pen);
   end

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         load_vec[i] = pat_beat && req_has_character && (eff_count == CNT_W'(i));
      end
   end

   assign links[0] = '0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      fss_cell #(
         .FIRST (i == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load      (load_vec[i]),
         .load_char (req_character),
         .prev      (links[i]),
         .link      (links[i+1]),
         .fin_v     (fin_v[i]),
         .fin       (fin[i])
      );
   end

   // Pick the cell of the last pattern byte
   always_comb begin
      tail_v = 1'b0;
      tail   = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (pcount_ff == CNT_W'(i + 1)) begin
            tail_v = tail_v | fin_v[i];
            tail   = tail | fin[i];
         end
      end
   end

   always_comb begin
      if (tcount_ff == TC_W'(MAX_TEXT)) begin
         tcount_step   = tcount_ff;
         overflow_step = 1'b1;
      end else begin
         tcount_step   = tcount_ff + 1'b1;
         overflow_step = overflow_ff;
      end
   end

   always_comb begin
      pcount_in    = pcount_ff;
      pdone_in     = pdone_ff;
      tcount_in    = tcount_ff;
      prev_char_in = prev_char_ff;
      overflow_in  = overflow_ff;
      if (pat_beat) begin
         pcount_in = eff_count;
         if (req_has_character && (eff_count < CNT_W'(MAX_PATTERN))) begin
            pcount_in = eff_count + 1'b1;
         end
         pdone_in = req_last;
      end else if (accept) begin
         pdone_in = 1'b1;
         if (text_step) begin
            tcount_in    = tcount_step;
            prev_char_in = req_character;
            overflow_in  = overflow_step;
         end
      end
      if (pat_beat || text_end) begin
         tcount_in    = '0;
         prev_char_in = '0;
         overflow_in  = 1'b0;
      end
   end

   always_comb begin
      pre_in.empty     = (pcount_ff == '0);
      pre_in.fin_v     = tail_v;
      pre_in.fin       = tail;
      pre_in.unmatched = text_step ? (SCORE_W'(tcount_step) - SCORE_W'(pcount_ff))
                                   : (SCORE_W'(tcount_ff) - SCORE_W'(pcount_ff));
      pre_in.overflow  = text_step ? overflow_step : overflow_ff;
      if (text_end) begin
         pre_valid_in = 1'b1;
      end else if (out_can) begin
         pre_valid_in = 1'b0;
      end else begin
         pre_valid_in = pre_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (text_end) begin
         pre_ff <= pre_in;
      end
      if (reset) begin
         pcount_ff    <= '0;
         pdone_ff     <= 1'b1;
         tcount_ff    <= '0;
         prev_char_ff <= '0;
         overflow_ff  <= 1'b0;
         pre_valid_ff <= 1'b0;
      end else begin
         pcount_ff    <= pcount_in;
         pdone_ff     <= pdone_in;
         tcount_ff    <= tcount_in;
         prev_char_ff <= prev_char_in;
         overflow_ff  <= overflow_in;
         pre_valid_ff <= pre_valid_in;
      end
   end

   fss_score u_score (
      .clock           (clock),
      .reset           (reset),
      .pre_valid       (pre_valid_ff),
      .pre             (pre_ff),
      .out_can         (out_can),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_score (rsp_match_score),
      .rsp_matched     (rsp_matched),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

// ===== rtl/core/fss_core_checker.sv =====
module fss_core_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_operation,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [fss_pkg::RSP_W-1:0] rsp_match_score,
   input logic                          rsp_matched,
   input logic                          rsp_too_long
);

   // A held result beat keeps its payload
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_match_score)
         && $stable(rsp_matched) && $stable(rsp_too_long)))
      else $error("result beat changed while stalled");

   // A fresh result must trace back to an accepted last text beat
   ap_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_operation && req_last, 2))
      else $error("result without a last text beat");

   // Input only backs up behind a stalled result
   ap_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with output free");

   // Unmatched texts report a zero score
   ap_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> (rsp_match_score == '0))
      else $error("nonzero score without a match");

endmodule

bind fuzzy_subsequence_scorer_core fss_core_checker u_fss_core_checker (.*);
